@@ sv/xdbt_pkg.sv @@
// Shared types and constants for the XOR distance bucket table.
// Holds the sequencer state type, request and register codes, and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package xdbt_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned ADDR_BITS_DEF = 48;

  localparam int unsigned ID_W       = 64;
  localparam int unsigned PEER_ADDR_W = 48;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_e;

endpackage

@@ sv/xor_distance_bucket_table.sv @@
// XOR distance peer bucket: slot table, sequencer and configuration registers.
// Depends on xdbt_pkg for codes, state type and default sizes.
// Usage:
//   Requests enter on in_valid_i / in_stall_o with operation_i, node_id_i and
//   peer_addr_i; a request is taken at an edge where in_valid_i is high and
//   in_stall_o is low. Each request gives one response on out_valid_o /
//   out_stall_i carrying success_o and entry_count_o.
//   Add and remove walk every slot through the id memory, one slot per
//   cycle, comparing each stored id with the request id and tracking the
//   slot farthest in XOR distance from the own id. Range queries and the
//   unused code skip the scan and go straight to the decision state.
//   One request is in flight at a time; in_stall_o is high while it runs, so
//   a new request is taken only once the last one reaches the output register.
//   The response sits in an output register, so the next request can be
//   taken while the receiver stalls; if the output register is still full
//   when the next response is ready, the sequencer holds until it drains.
//   Configuration writes (own id, range bounds) use cfg_valid_i/cfg_ready_o
//   and are always ready; write them only while no request is in flight.
//   Reset empties the table and clears the registers to zero.
`timescale 1ns / 1ps

module xor_distance_bucket_table
  import xdbt_pkg::*;
#(
  parameter int unsigned BUCKET_SLOTS = SLOTS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_W-1:0]        operation_i,
  input  logic [ID_W-1:0]        node_id_i,
  input  logic [PEER_ADDR_W-1:0] peer_addr_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   success_o,
  output logic [COUNT_W-1:0]     entry_count_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ID_W-1:0]        cfg_data_i
);

  localparam int unsigned IDX_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(BUCKET_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_SLOTS - 1);
  localparam logic [IDX_W:0]   SLOTS_N  = (IDX_W + 1)'(BUCKET_SLOTS);

  state_e state_q, state_d;

  logic [ID_W-1:0] own_q, lower_q, upper_q;

  logic [OP_W-1:0]      op_q;
  logic [ID_W-1:0]      id_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic [BUCKET_SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]        count_q, count_d;

  // scan pipeline
  logic [IDX_W:0]   rd_idx_q, rd_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [ID_W-1:0]  rd_id_q;

  logic             found_q, found_d;
  logic [IDX_W-1:0] found_idx_q, found_idx_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             victim_q, victim_d;
  logic [IDX_W-1:0] victim_idx_q, victim_idx_d;
  logic [ID_W-1:0]  far_q, far_d;

  logic success_q, success_d;
  logic out_valid_q, out_valid_d;
  logic out_success_q;
  logic [COUNT_W-1:0] out_count_q;
  logic load_out;

  logic [ID_W-1:0]      id_mem   [BUCKET_SLOTS];
  logic [ADDR_BITS-1:0] addr_mem [BUCKET_SLOTS];
  logic                 wr_en, wr_id_en;
  logic [IDX_W-1:0]     wr_idx;

  logic                      in_accept;
  logic [ID_W-1:0]           scan_dist, req_dist;
  logic [ADDR_BITS+PEER_ADDR_W-1:0] addr_ext;
  logic [CNT_W+COUNT_W-1:0]  count_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign addr_ext    = {{ADDR_BITS{1'b0}}, peer_addr_i};
  assign scan_dist   = rd_id_q ^ own_q;
  assign req_dist    = id_q ^ own_q;
  assign count_ext   = {{COUNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= '0;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_OWN_ID:      own_q   <= cfg_data_i;
        REG_RANGE_LOWER: lower_q <= cfg_data_i;
        REG_RANGE_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot memories: one write port, registered read of the scan address
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= addr_q;
      if (wr_id_en) begin
        id_mem[wr_idx] <= id_q;
      end
    end
    rd_id_q <= id_mem[rd_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= operation_i;
      id_q   <= node_id_i;
      addr_q <= addr_ext[ADDR_BITS-1:0];
    end
    cmp_idx_q    <= cmp_idx_d;
    found_idx_q  <= found_idx_d;
    free_idx_q   <= free_idx_d;
    victim_idx_q <= victim_idx_d;
    far_q        <= far_d;
    success_q    <= success_d;
    if (load_out) begin
      out_success_q <= success_q;
      out_count_q   <= count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      victim_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      free_q      <= free_d;
      victim_q    <= victim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    victim_d     = victim_q;
    victim_idx_d = victim_idx_q;
    far_d        = far_q;
    success_d    = success_q;
    wr_en        = 1'b0;
    wr_id_en     = 1'b0;
    wr_idx       = found_idx_q;
    load_out     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rd_idx_d = '0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          victim_d = 1'b0;
          far_d    = '0;
          if (operation_i == OP_ADD || operation_i == OP_REMOVE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_SCAN: begin
        // issue one slot read per cycle, compare the slot read last cycle
        if (rd_idx_q < SLOTS_N) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (valid_q[cmp_idx_q]) begin
            if (rd_id_q == id_q) begin
              found_d     = 1'b1;
              found_idx_d = cmp_idx_q;
            end
            if (far_q < scan_dist) begin
              far_d        = scan_dist;
              victim_d     = 1'b1;
              victim_idx_d = cmp_idx_q;
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == LAST_IDX) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        success_d = 1'b0;
        unique case (op_q)
          OP_ADD: begin
            if (found_q) begin
              wr_en     = 1'b1;
              wr_idx    = found_idx_q;
              success_d = 1'b1;
            end else if (free_q) begin
              wr_en             = 1'b1;
              wr_id_en          = 1'b1;
              wr_idx            = free_idx_q;
              valid_d[free_idx_q] = 1'b1;
              count_d           = count_q + 1'b1;
              success_d         = 1'b1;
            end else if (victim_q && (req_dist < far_q)) begin
              wr_en     = 1'b1;
              wr_id_en  = 1'b1;
              wr_idx    = victim_idx_q;
              success_d = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (found_q) begin
              valid_d[found_idx_q] = 1'b0;
              count_d              = count_q - 1'b1;
              success_d            = 1'b1;
            end
          end
          OP_RANGE: begin
            success_d = (lower_q <= req_dist) && (req_dist < upper_q);
          end
          default: ;
        endcase
        state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register can take the response
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = out_success_q;
  assign entry_count_o = out_count_q;

endmodule
